// File: rtl/assert_macros.svh
// Assertion macros used by the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/cfp_pkg.sv
// Package with the codes and the queue item type of the column predicate filter.
`timescale 1ns / 1ps

package cfp_pkg;

    // Item function codes.
    localparam logic [2:0] FUNC_SCALAR_ROW = 3'd0;
    localparam logic [2:0] FUNC_STR_BYTE   = 3'd1;
    localparam logic [2:0] FUNC_STR_END    = 3'd2;
    localparam logic [2:0] FUNC_LOAD_CONST = 3'd3;
    localparam logic [2:0] FUNC_GROUP      = 3'd4;

    // Column types.
    localparam logic [1:0] COL_INT    = 2'd0;
    localparam logic [1:0] COL_DOUBLE = 2'd1;
    localparam logic [1:0] COL_STRING = 2'd2;

    // Comparison operators.
    localparam logic [2:0] OP_LT = 3'd0;
    localparam logic [2:0] OP_LE = 3'd1;
    localparam logic [2:0] OP_GT = 3'd2;
    localparam logic [2:0] OP_GE = 3'd3;
    localparam logic [2:0] OP_EQ = 3'd4;
    localparam logic [2:0] OP_NE = 3'd5;

    // String order so far.
    localparam logic [1:0] ORD_EQUAL   = 2'd0;
    localparam logic [1:0] ORD_LESS    = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_COLUMN_TYPE  = 3'd0;
    localparam logic [2:0] REG_COMPARE_OP   = 3'd1;
    localparam logic [2:0] REG_CONST_INT    = 3'd2;
    localparam logic [2:0] REG_CONST_DOUBLE = 3'd3;
    localparam logic [2:0] REG_CONST_LEN    = 3'd4;

    // Row item handed from the front to the back.
    typedef struct packed {
        logic        is_str;
        logic        is_null;
        logic [31:0] row;
        logic [63:0] value;
        logic [1:0]  ord;
    } row_item_t;

    // Comparison settings used by the back.
    typedef struct packed {
        logic [1:0]  col_kind;
        logic [2:0]  compare_op;
        logic [31:0] int_const;
        logic [63:0] const_double_bits;
    } cmp_cfg_t;

endpackage

// File: rtl/cfp_front.sv
// Front part: accepts items, keeps row count, string order state and constant bytes.
`timescale 1ns / 1ps

module cfp_front
    import cfp_pkg::*;
#(
    parameter int MAX_CONST_LEN = 64
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [2:0]      func,
    input  logic [63:0]     value,
    input  logic [7:0]      data_byte,
    input  logic [5:0]      const_index,
    input  logic            is_null,
    input  logic [6:0]      const_len,
    output logic            push,
    output row_item_t       push_item,
    output logic [31:0]     rows_seen
);

    localparam int AW  = (MAX_CONST_LEN > 1) ? $clog2(MAX_CONST_LEN) : 1;
    localparam int BPW = $clog2(MAX_CONST_LEN + 1);
    localparam int PW  = (BPW > 7) ? BPW : 7;

    logic [31:0]    row_reg, row_next;
    logic [BPW-1:0] bp_reg, bp_next;
    logic [1:0]     ord_reg, ord_next;
    logic [7:0]     mem [MAX_CONST_LEN];
    logic [7:0]     rd_reg;
    logic           we;
    logic [AW-1:0]  waddr, raddr;
    logic           bp_in_len;
    logic           bp_below_max;
    logic [1:0]     end_ord;

    assign bp_below_max = bp_reg < BPW'(MAX_CONST_LEN);
    assign bp_in_len    = (PW'(bp_reg) < PW'(const_len)) && bp_below_max;

    // A row ending while still equal but short of the constant orders as less.
    assign end_ord = (ord_reg == ORD_EQUAL && bp_in_len) ? ORD_LESS : ord_reg;

    assign we    = accept && (func == FUNC_LOAD_CONST)
                   && (32'(const_index) < 32'(MAX_CONST_LEN));
    assign waddr = AW'(const_index);
    assign raddr = AW'(bp_next);

    // Next state of the counters and the string comparison.
    always_comb
    begin
        row_next = row_reg;
        bp_next  = bp_reg;
        ord_next = ord_reg;
        push     = 1'b0;
        push_item.is_str  = (func == FUNC_STR_END);
        push_item.is_null = is_null;
        push_item.row     = row_reg;
        push_item.value   = value;
        push_item.ord     = end_ord;
        if (accept)
        begin
            case (func)
                FUNC_SCALAR_ROW:
                begin
                    push     = 1'b1;
                    row_next = row_reg + 32'd1;
                end
                FUNC_STR_BYTE:
                begin
                    if (ord_reg == ORD_EQUAL)
                    begin
                        if (!bp_in_len)
                        begin
                            ord_next = ORD_GREATER;
                        end
                        else if (data_byte < rd_reg)
                        begin
                            ord_next = ORD_LESS;
                        end
                        else if (data_byte > rd_reg)
                        begin
                            ord_next = ORD_GREATER;
                        end
                    end
                    if (bp_below_max)
                    begin
                        bp_next = bp_reg + BPW'(1);
                    end
                end
                FUNC_STR_END:
                begin
                    push     = 1'b1;
                    row_next = row_reg + 32'd1;
                    bp_next  = '0;
                    ord_next = ORD_EQUAL;
                end
                FUNC_GROUP:
                begin
                    row_next = '0;
                    bp_next  = '0;
                    ord_next = ORD_EQUAL;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            bp_reg  <= '0;
            ord_reg <= ORD_EQUAL;
        end
        else
        begin
            row_reg <= row_next;
            bp_reg  <= bp_next;
            ord_reg <= ord_next;
        end
    end

    // Constant byte memory; the read prefetches the byte at the next position.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= data_byte;
        end
        if (we && waddr == raddr)
        begin
            rd_reg <= data_byte;
        end
        else
        begin
            rd_reg <= mem[raddr];
        end
    end

    assign rows_seen = row_reg;

endmodule

// File: rtl/cfp_fifo.sv
// Two-entry queue of row items between the front and the back.
`timescale 1ns / 1ps

module cfp_fifo
    import cfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  row_item_t push_item,
    input  logic      pop,
    output logic      full,
    output logic      not_empty,
    output row_item_t head,
    output logic [1:0] level
);

    row_item_t  slot_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] count_reg;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = slot_reg[rd_reg];
    assign level     = count_reg;

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    // Item storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/cfp_back.sv
// Back part: compares each queued row item and presents the index of a matching row.
`timescale 1ns / 1ps

module cfp_back
    import cfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmp_cfg_t    cfg,
    input  logic        head_valid,
    input  row_item_t   head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] row_index
);

    logic        out_valid_reg;
    logic [31:0] row_index_reg;
    logic        int_lt, int_eq;
    logic        a_nan, c_nan, both_zero;
    logic [63:0] a_key, c_key;
    logic        dbl_lt, dbl_eq, dbl_gt;
    logic        lt, eq, gt;
    logic        op_hit;
    logic        match;

    function automatic logic [63:0] order_key(input logic [63:0] b);
        order_key = b[63] ? ~b : {1'b1, b[62:0]};
    endfunction

    // Integer comparison.
    assign int_lt = $signed(head.value[31:0]) < $signed(cfg.int_const);
    assign int_eq = head.value[31:0] == cfg.int_const;

    // Double comparison through sign-magnitude order keys.
    assign a_nan     = (&head.value[62:52]) && (|head.value[51:0]);
    assign c_nan     = (&cfg.const_double_bits[62:52]) && (|cfg.const_double_bits[51:0]);
    assign both_zero = ~|head.value[62:0] && ~|cfg.const_double_bits[62:0];
    assign a_key     = order_key(head.value);
    assign c_key     = order_key(cfg.const_double_bits);
    assign dbl_eq    = !a_nan && !c_nan && (both_zero || a_key == c_key);
    assign dbl_lt    = !a_nan && !c_nan && !both_zero && a_key < c_key;
    assign dbl_gt    = !a_nan && !c_nan && !dbl_eq && !dbl_lt;

    // Select the order of the item and apply the operator.
    always_comb
    begin
        lt = 1'b0;
        eq = 1'b0;
        gt = 1'b0;
        if (head.is_str)
        begin
            lt = head.ord == ORD_LESS;
            eq = head.ord == ORD_EQUAL;
            gt = head.ord == ORD_GREATER;
        end
        else if (cfg.col_kind == COL_INT)
        begin
            lt = int_lt;
            eq = int_eq;
            gt = !int_lt && !int_eq;
        end
        else
        begin
            lt = dbl_lt;
            eq = dbl_eq;
            gt = dbl_gt;
        end
        case (cfg.compare_op)
            OP_LT:   op_hit = lt;
            OP_LE:   op_hit = lt || eq;
            OP_GT:   op_hit = gt;
            OP_GE:   op_hit = gt || eq;
            OP_EQ:   op_hit = eq;
            OP_NE:   op_hit = !eq;
            default: op_hit = 1'b0;
        endcase
    end

    // A row matches only if it is not null and its kind fits the column type.
    assign match = !head.is_null && op_hit
                   && (head.is_str ? (cfg.col_kind == COL_STRING)
                       : (cfg.col_kind == COL_INT || cfg.col_kind == COL_DOUBLE));

    assign pop = head_valid && (!out_valid_reg || out_ready);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= match;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && match)
        begin
            row_index_reg <= head.row;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_index = row_index_reg;

endmodule

// File: rtl/column_predicate_filter.sv
// Top level of the column predicate filter: configuration registers and part wiring.
// An accepted item is registered in a queue slot, then a matching row's index in the output register.
// Throughput: one item per cycle while the queue is not full, for every item kind.
// The two-entry queue and the output register let each side stall on its own.
// Reset: asynchronous, active low; control and config registers return to reset values, compare_op to equal.
// The constant byte memory has no reset and holds garbage until loaded.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module column_predicate_filter
    import cfp_pkg::*;
#(
    parameter int MAX_CONST_LEN = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [63:0] value,
    input  logic [7:0]  data_byte,
    input  logic [5:0]  const_index,
    input  logic        is_null,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] row_index,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    cmp_cfg_t    cfg_reg;
    logic [6:0]  const_len_reg;
    logic        accept;
    logic        push;
    row_item_t   push_item;
    logic        full;
    logic        not_empty;
    row_item_t   head;
    logic        pop;
    logic [1:0]  level;
    logic [31:0] rows_seen;

    assign cfg_ready = 1'b1;
    assign in_ready  = !full;
    assign accept    = in_valid && in_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.col_kind          <= COL_INT;
            cfg_reg.compare_op        <= OP_EQ;
            cfg_reg.int_const         <= '0;
            cfg_reg.const_double_bits <= '0;
            const_len_reg             <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_COLUMN_TYPE:  cfg_reg.col_kind          <= cfg_data[1:0];
                REG_COMPARE_OP:   cfg_reg.compare_op        <= cfg_data[2:0];
                REG_CONST_INT:    cfg_reg.int_const         <= cfg_data[31:0];
                REG_CONST_DOUBLE: cfg_reg.const_double_bits <= cfg_data;
                REG_CONST_LEN:    const_len_reg             <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    cfp_front #(
        .MAX_CONST_LEN (MAX_CONST_LEN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .func        (func),
        .value       (value),
        .data_byte   (data_byte),
        .const_index (const_index),
        .is_null     (is_null),
        .const_len   (const_len_reg),
        .push        (push),
        .push_item   (push_item),
        .rows_seen   (rows_seen)
    );

    cfp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head),
        .level     (level)
    );

    cfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (not_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .row_index  (row_index)
    );

    // The queue never holds more than two items.
    `ASSERT_IMPLIES(a_level_max, clk, rst_n, 1'b1, level <= 2'd2)
    // A group start clears the row counter.
    `ASSERT_NEXT(a_group_clear, clk, rst_n, accept && func == FUNC_GROUP, rows_seen == 32'd0)
    // A full queue takes no new item.
    `ASSERT_IMPLIES(a_full_stall, clk, rst_n, level == 2'd2, !in_ready)

endmodule
